[design/slsc_pkg.sv]
// ----------------------------------------------------------------------------
// slsc_pkg: shared types and constants for the scrolling level strip chart
// Holds the sequencer state type, the band search result, the reset full
// scale and the fixed over-range pattern.
// ----------------------------------------------------------------------------
package slsc_pkg;

    localparam int unsigned BAND_COUNT = 8;
    localparam int unsigned IDX_W = $clog2(BAND_COUNT);

    localparam logic [15:0] RESET_FULL_SCALE = 16'd65000;

    // Register map, word index taken from paddr[2].
    localparam logic REG_FULL_SCALE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             done;
        logic             over;
        logic [IDX_W-1:0] band;
    } band_result_t;

    // Row bytes shown when a sample lies above the top band.
    function automatic logic [7:0] error_row(input logic [IDX_W-1:0] row);
        logic [7:0] pattern;
        case (row)
            3'd0:    pattern = 8'h00;
            3'd1:    pattern = 8'h7e;
            3'd2:    pattern = 8'h46;
            3'd3:    pattern = 8'h4a;
            3'd4:    pattern = 8'h52;
            3'd5:    pattern = 8'h62;
            3'd6:    pattern = 8'h7e;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

[design/slsc_band_search.sv]
// ----------------------------------------------------------------------------
// slsc_band_search: iterative band classifier
// One adder and one comparator walk the band edges step, 2*step, ... and
// report the first edge above the sample, or over range when the sample is at or above every edge.
// ----------------------------------------------------------------------------
module slsc_band_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [15:0]                 sample,
    input  logic [15:0]                 full_scale,
    output slsc_pkg::band_result_t      result
);

    logic                        busy_reg, busy_next;
    logic [15:0]                 edge_reg, edge_next;
    logic [12:0]                 step_reg, step_next;
    logic [slsc_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic                        below;

    assign below = sample < edge_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        edge_next   = edge_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        result.done = 1'b0;
        result.over = 1'b0;
        result.band = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = full_scale[15:3];
            edge_next = {3'b000, full_scale[15:3]};
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (below)
            begin
                result.done = 1'b1;
                busy_next   = 1'b0;
            end
            else if (cnt_reg == slsc_pkg::IDX_W'(slsc_pkg::BAND_COUNT - 1))
            begin
                result.done = 1'b1;
                result.over = 1'b1;
                busy_next   = 1'b0;
            end
            else
            begin
                // The top edge is at most 8 * 8191, so 16 bits never wrap.
                edge_next = edge_reg + {3'b000, step_reg};
                cnt_next  = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
        step_reg <= step_next;
        cnt_reg  <= cnt_next;
    end

endmodule

[design/scrolling_level_strip_chart.sv]
// ----------------------------------------------------------------------------
// scrolling_level_strip_chart: eight-column scrolling level display driver
// Sorts each sample into one of eight bands or over range, scrolls the history
// when in range and emits the eight display row writes for the new picture.
// ----------------------------------------------------------------------------
// Usage:
// A sample enters on the sample channel (valid/ready). The block is ready
// only while idle; once a transaction is taken, the band search compares the
// sample against one band edge per cycle, using the single shared adder and
// comparator in the search unit. Then eight row write transactions leave on
// the output channel, addresses 1 (oldest column) to 8 (newest), one per
// cycle when the receiver is ready, with last_write high on the eighth. The
// next sample is accepted only once the block is idle again after the eighth
// write. A sample at or above eight bands leaves the history alone and the
// eight writes carry the fixed error picture with over_range set. When the
// receiver stalls, the current write holds steady until taken and no new
// sample is accepted. Reset blanks the history and loads the default full
// scale of 65000. full_scale is written over the APB port at byte address 0;
// the user must write it only while the block is idle, as the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module scrolling_level_strip_chart (
    input  logic        clk,
    input  logic        rst_n,
    // Sample channel
    input  logic        valid_in,
    output logic        ready_in,
    input  logic [15:0] sample,
    // Row write channel
    output logic        valid_out,
    input  logic        ready_out,
    output logic [3:0]  row_address,
    output logic [7:0]  row_data,
    output logic        last_write,
    output logic        over_range,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [slsc_pkg::IDX_W-1:0] LAST_ROW =
        slsc_pkg::IDX_W'(slsc_pkg::BAND_COUNT - 1);

    slsc_pkg::state_t             state_reg, state_next;
    logic [15:0]                  full_scale_reg;
    logic [15:0]                  sample_reg;
    logic [7:0]                   history_reg [slsc_pkg::BAND_COUNT];
    logic [slsc_pkg::IDX_W-1:0]   row_reg, row_next;
    logic                         over_reg, over_next;
    logic                         search_start;
    logic                         in_take;
    logic                         out_take;
    logic                         shift_en;
    slsc_pkg::band_result_t       search_res;

    // The register map holds one word; paddr[2] selects it, the byte offset
    // within the word is ignored.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == slsc_pkg::REG_FULL_SCALE) ?
                    {16'h0000, full_scale_reg} : 32'h0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= slsc_pkg::RESET_FULL_SCALE;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr[2] == slsc_pkg::REG_FULL_SCALE)
        begin
            full_scale_reg <= pwdata[15:0];
        end
    end

    slsc_band_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (search_start),
        .sample     (sample_reg),
        .full_scale (full_scale_reg),
        .result     (search_res)
    );

    assign in_take  = valid_in && ready_in;
    assign out_take = valid_out && ready_out;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slsc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = slsc_pkg::ST_SEARCH;
                end
            end
            slsc_pkg::ST_SEARCH:
            begin
                if (search_res.done)
                begin
                    state_next = slsc_pkg::ST_EMIT;
                end
            end
            slsc_pkg::ST_EMIT:
            begin
                if (out_take && row_reg == LAST_ROW)
                begin
                    state_next = slsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath controls.
    always_comb
    begin
        ready_in     = 1'b0;
        valid_out    = 1'b0;
        search_start = 1'b0;
        shift_en     = 1'b0;
        row_next     = row_reg;
        over_next    = over_reg;
        case (state_reg)
            slsc_pkg::ST_IDLE:
            begin
                ready_in     = 1'b1;
                search_start = in_take;
            end
            slsc_pkg::ST_SEARCH:
            begin
                if (search_res.done)
                begin
                    shift_en  = !search_res.over;
                    over_next = search_res.over;
                    row_next  = '0;
                end
            end
            slsc_pkg::ST_EMIT:
            begin
                valid_out = 1'b1;
                if (out_take)
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            default:
            begin
                ready_in = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slsc_pkg::ST_IDLE;
            for (int i = 0; i < slsc_pkg::BAND_COUNT; i++)
            begin
                history_reg[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (shift_en)
            begin
                // Scroll toward the oldest column; the newest gets the band bit.
                for (int i = 0; i < slsc_pkg::BAND_COUNT - 1; i++)
                begin
                    history_reg[i] <= history_reg[i + 1];
                end
                history_reg[slsc_pkg::BAND_COUNT - 1] <= 8'h01 << search_res.band;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        over_reg <= over_next;
        if (in_take)
        begin
            sample_reg <= sample;
        end
    end

    assign row_address = {1'b0, row_reg} + 4'd1;
    assign row_data    = over_reg ? slsc_pkg::error_row(row_reg) : history_reg[row_reg];
    assign last_write  = (row_reg == LAST_ROW);
    assign over_range  = over_reg;

endmodule
